### design/centroid_outlier_trimmer_defines.svh
// Assertion macros for the centroid outlier trimmer.
// Used by the top level; no other dependencies.
`ifndef CENTROID_OUTLIER_TRIMMER_DEFINES_SVH
`define CENTROID_OUTLIER_TRIMMER_DEFINES_SVH
`ifndef SYNTHESIS
`define COT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define COT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define COT_ASSERT(lbl, prop, msg)
`define COT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### design/cot_pkg.sv
// Shared types and constants for the centroid outlier trimmer.
// No dependencies.
`default_nettype none
package cot_pkg;
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_W = 24;
	localparam int DIST_W = 52;
	localparam int PCT_W = 7;
	localparam logic [PCT_W-1:0] PCT_RESET = 7'd1;
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
	// floor(x/100) as (x*RECIP)>>RECIP_SH, exact for x below 6400
	localparam int RECIP = 5243;
	localparam int RECIP_SH = 19;

	typedef enum logic [3:0] {
		S_LOAD, S_DIV, S_DIVW, S_DRD, S_DAX, S_DWR, S_KEEP,
		S_SRD, S_SCMP, S_ERD, S_ELD, S_DONE
	} state_t;
endpackage
`default_nettype wire

### design/cot_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module cot_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire                 clk,
	input  wire                 we,
	input  wire [$clog2(D)-1:0] waddr,
	input  wire [W-1:0]         wdata,
	input  wire [$clog2(D)-1:0] raddr,
	output logic [W-1:0]        rdata
);
	logic [W-1:0] mem_q [D];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### design/cot_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Divides a signed sum by an unsigned count; no package dependencies.
`default_nettype none
module cot_div #(
	parameter int NW = 30,
	parameter int DW = 7
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire signed [NW-1:0] num,
	input  wire [DW-1:0]        den,
	output logic                done,
	output logic signed [NW-1:0] quo
);
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    mag_q;
	logic [DW-1:0]    rem_q;
	logic             neg_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             qbit;

	// trial subtract of the next dividend bit
	always_comb begin
		trial = {rem_q, mag_q[NW-1]};
		qbit = (trial >= {1'b0, den});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: magnitude shifts out, quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1];
			mag_q <= num[NW-1] ? (-num) : num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
			mag_q <= {mag_q[NW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo = neg_q ? (-$signed(mag_q)) : $signed(mag_q);
endmodule
`default_nettype wire

### design/centroid_outlier_trimmer.sv
// Centroid outlier trimmer: loads points at one beat per cycle until the final one,
// then divides the three axis sums serially, computes distances with one shared
// multiplier, and emits kept points by repeated scans of the distance RAM.
// Input stalls until done.
// Reset (arst_n, asynchronous) empties the set and sets removal_percent to 1.
`default_nettype none
`include "centroid_outlier_trimmer_defines.svh"
module centroid_outlier_trimmer #(
	parameter int MAX_POINTS = cot_pkg::MAX_POINTS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [cot_pkg::PCT_W-1:0]        removal_percent,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire signed [cot_pkg::COORD_W-1:0] point_x,
	input  wire signed [cot_pkg::COORD_W-1:0] point_y,
	input  wire signed [cot_pkg::COORD_W-1:0] point_z,
	input  wire                             final_point,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic signed [cot_pkg::COORD_W-1:0] kept_x,
	output logic signed [cot_pkg::COORD_W-1:0] kept_y,
	output logic signed [cot_pkg::COORD_W-1:0] kept_z,
	output logic                            end_of_run,
	output logic                            capacity_exceeded
);
	import cot_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SW = COORD_W + AW;
	localparam int PW = CW + PCT_W;
	localparam int RW = PW + 14;
	localparam int XW = 3 * COORD_W;
	localparam int SQW = 2 * (COORD_W + 1);

	state_t state_q, state_d;

	logic [PCT_W-1:0]    pct_q;
	logic signed [SW-1:0] sum_q [3];
	logic [CW-1:0]       count_q;
	logic                overflow_q;
	logic signed [COORD_W-1:0] cen_q [3];
	logic [1:0]          k_q;
	logic [AW-1:0]       i_q, j_q, best_i_q, last_i_q;
	logic [CW-1:0]       keep_q, e_q;
	logic [SQW-1:0]      prod_q;
	logic [DIST_W-1:0]   acc_q, best_d_q, last_d_q;
	logic                hb_q;

	logic                in_acc, store;
	logic                div_start, div_done;
	logic signed [SW-1:0] div_quo;
	logic [XW-1:0]       xyz_rdata;
	logic [AW-1:0]       xyz_raddr;
	logic [DIST_W-1:0]   dist_rdata;
	logic [DIST_W-1:0]   dist_new;
	logic signed [COORD_W-1:0] coord_sel;
	logic signed [COORD_W:0] diff;
	logic [PCT_W-1:0]    pct_eff;
	logic [PW-1:0]       prodn;
	logic [RW-1:0]       scaled;
	logic [CW-1:0]       remove_n;
	logic                cand, better, out_free;
	logic [AW-1:0]       last_idx;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_LOAD);
	assign in_acc = in_valid && !in_stall;
	assign store = in_acc && (count_q < CW'(MAX_POINTS));
	assign last_idx = AW'(count_q - CW'(1));
	assign out_free = !out_valid || !out_stall;

	// coordinate and distance storage
	assign xyz_raddr = (state_q == S_ERD || state_q == S_ELD) ? best_i_q : i_q;
	cot_ram #(.W(XW), .D(MAX_POINTS)) u_xyz (
		.clk(clk), .we(store), .waddr(count_q[AW-1:0]),
		.wdata({point_z, point_y, point_x}), .raddr(xyz_raddr), .rdata(xyz_rdata)
	);
	assign dist_new = acc_q + DIST_W'(prod_q);
	cot_ram #(.W(DIST_W), .D(MAX_POINTS)) u_dist (
		.clk(clk), .we(state_q == S_DWR), .waddr(i_q),
		.wdata(dist_new), .raddr(j_q), .rdata(dist_rdata)
	);

	// centroid division, one axis at a time
	assign div_start = (state_q == S_DIV);
	cot_div #(.NW(SW), .DW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(sum_q[k_q]), .den(count_q), .done(div_done), .quo(div_quo)
	);

	// axis difference for the shared multiplier
	always_comb begin
		unique case (k_q)
			2'd0: coord_sel = xyz_rdata[COORD_W-1:0];
			2'd1: coord_sel = xyz_rdata[2*COORD_W-1:COORD_W];
			default: coord_sel = xyz_rdata[XW-1:2*COORD_W];
		endcase
		diff = (COORD_W+1)'(coord_sel) - (COORD_W+1)'(cen_q[k_q]);
	end

	// removal count: floor(n * min(pct, 100) / 100)
	always_comb begin
		pct_eff = (pct_q > PCT_MAX) ? PCT_MAX : pct_q;
		prodn = PW'(count_q) * PW'(pct_eff);
		scaled = RW'(prodn) * RW'(RECIP);
		remove_n = CW'(scaled >> RECIP_SH);
	end

	// scan: next key above the last emitted one, lowest first
	always_comb begin
		cand = (e_q == '0) || (dist_rdata > last_d_q) ||
			((dist_rdata == last_d_q) && (j_q > last_i_q));
		better = !hb_q || (dist_rdata < best_d_q);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: if (in_acc && final_point) state_d = S_DIV;
			S_DIV: state_d = S_DIVW;
			S_DIVW: if (div_done) state_d = (k_q == 2'd2) ? S_DRD : S_DIV;
			S_DRD: state_d = S_DAX;
			S_DAX: if (k_q == 2'd2) state_d = S_DWR;
			S_DWR: state_d = (i_q == last_idx) ? S_KEEP : S_DRD;
			S_KEEP: state_d = (count_q == remove_n) ? S_DONE : S_SRD;
			S_SRD: state_d = S_SCMP;
			S_SCMP: state_d = (j_q == last_idx) ? S_ERD : S_SRD;
			S_ERD: state_d = S_ELD;
			S_ELD: if (out_free) state_d = (e_q == keep_q - CW'(1)) ? S_DONE : S_SRD;
			S_DONE: state_d = S_LOAD;
			default: state_d = S_LOAD;
		endcase
	end

	// set accumulation and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= PCT_RESET;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
			count_q <= '0;
			overflow_q <= 1'b0;
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
			e_q <= '0;
			keep_q <= '0;
			hb_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) pct_q <= removal_percent;
			// raise on a loaded beat, drop once taken
			if (state_q == S_ELD && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (store) begin
						sum_q[0] <= sum_q[0] + SW'(point_x);
						sum_q[1] <= sum_q[1] + SW'(point_y);
						sum_q[2] <= sum_q[2] + SW'(point_z);
						count_q <= count_q + CW'(1);
					end else if (in_acc) begin
						overflow_q <= 1'b1;
					end
					k_q <= '0;
					i_q <= '0;
				end
				S_DIVW: if (div_done) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				S_DAX: k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				S_DWR: i_q <= i_q + AW'(1);
				S_KEEP: begin
					keep_q <= count_q - remove_n;
					e_q <= '0;
					j_q <= '0;
					hb_q <= 1'b0;
				end
				S_SCMP: begin
					if (cand && better) hb_q <= 1'b1;
					if (j_q != last_idx) j_q <= j_q + AW'(1);
				end
				S_ELD: begin
					if (out_free) begin
						e_q <= e_q + CW'(1);
						j_q <= '0;
						hb_q <= 1'b0;
					end
				end
				S_DONE: begin
					sum_q[0] <= '0;
					sum_q[1] <= '0;
					sum_q[2] <= '0;
					count_q <= '0;
					overflow_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_DIVW && div_done) cen_q[k_q] <= COORD_W'(div_quo);
		if (state_q == S_DAX) begin
			prod_q <= SQW'(diff * diff);
			acc_q <= (k_q == 2'd0) ? '0 : acc_q + DIST_W'(prod_q);
		end
		if (state_q == S_SCMP && cand && better) begin
			best_d_q <= dist_rdata;
			best_i_q <= j_q;
		end
		if (state_q == S_ELD && out_free) begin
			last_d_q <= best_d_q;
			last_i_q <= best_i_q;
			kept_x <= xyz_rdata[COORD_W-1:0];
			kept_y <= xyz_rdata[2*COORD_W-1:COORD_W];
			kept_z <= xyz_rdata[XW-1:2*COORD_W];
			end_of_run <= (e_q == keep_q - CW'(1));
			capacity_exceeded <= overflow_q;
		end
	end

	`COT_ASSERT(a_count_bound, count_q <= CW'(MAX_POINTS), "point count beyond capacity")
	`COT_ASSERT(a_ovf_full, overflow_q |-> (count_q == CW'(MAX_POINTS)), "overflow before full")
	`COT_ASSERT_ALWAYS(a_emit_range, (state_q == S_ELD) |-> (e_q < keep_q), "emit past keep count")
endmodule
`default_nettype wire
